[rtl/core/ght_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Generational handle table package
// Shared widths, operation and status codes, and the control interface types
// between the sequencer and the datapath.
// ============================================================================
package ght_pkg;

   localparam int NUM_SLOTS_DEFAULT = 64;
   localparam int GEN_BITS_DEFAULT  = 32;

   localparam int OP_W     = 2;
   localparam int HSLOT_W  = 6;
   localparam int HGEN_W   = 32;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 7;

   localparam logic [OP_W-1:0] OP_CREATE  = 2'd0;
   localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;
   localparam logic [OP_W-1:0] OP_DISPOSE = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_STALE    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_DISPOSED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_AGAIN    = 3'd4;

   typedef struct packed {
      logic load;
      logic lookup;
      logic update;
      logic link;
      logic emit;
   } ght_cmd_type;

   typedef struct packed {
      logic lookup_final;
      logic update_final;
      logic walk_again;
   } ght_sts_type;

endpackage
`default_nettype wire

[rtl/core/ght_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Generational handle table channels
// Valid/ready channels for requests and responses.
// ============================================================================
interface ght_req_if import ght_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     operation;
   logic [HSLOT_W-1:0]  handle_slot;
   logic [HGEN_W-1:0]   handle_generation;

   modport source (output valid, output operation, output handle_slot,
                   output handle_generation, input ready);
   modport sink (input valid, input operation, input handle_slot,
                 input handle_generation, output ready);
endinterface

interface ght_rsp_if import ght_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [HSLOT_W-1:0]  result_slot;
   logic [HGEN_W-1:0]   result_generation;
   logic                handle_alive;
   logic [COUNT_W-1:0]  live_count;
   logic [COUNT_W-1:0]  released_count;

   modport source (output valid, output status, output result_slot,
                   output result_generation, output handle_alive,
                   output live_count, output released_count, input ready);
   modport sink (input valid, input status, input result_slot,
                 input result_generation, input handle_alive,
                 input live_count, input released_count, output ready);
endinterface
`default_nettype wire

[rtl/core/ght_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Generational handle table datapath
// Slot tables, list pointers, counters and the response register.
// ============================================================================
module ght_datapath import ght_pkg::*; #(
   parameter int NUM_SLOTS = NUM_SLOTS_DEFAULT,
   parameter int GEN_BITS  = GEN_BITS_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire ght_cmd_type         cmd,
   output      ght_sts_type         sts,
   input  wire logic [OP_W-1:0]     req_operation,
   input  wire logic [HSLOT_W-1:0]  req_handle_slot,
   input  wire logic [HGEN_W-1:0]   req_handle_generation,
   output      logic [STATUS_W-1:0] rsp_status,
   output      logic [HSLOT_W-1:0]  rsp_result_slot,
   output      logic [HGEN_W-1:0]   rsp_result_generation,
   output      logic                rsp_handle_alive,
   output      logic [COUNT_W-1:0]  rsp_live_count,
   output      logic [COUNT_W-1:0]  rsp_released_count
);

   localparam int SLOT_W    = $clog2(NUM_SLOTS);
   localparam int LINK_W    = $clog2(NUM_SLOTS + 1);
   localparam int MEM_DEPTH = 1 << SLOT_W;
   localparam int CMP_W     = LINK_W + HSLOT_W;
   localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(NUM_SLOTS);

   logic [GEN_BITS:0]   state_mem [MEM_DEPTH];
   logic [LINK_W-1:0]   next_mem  [MEM_DEPTH];
   logic [LINK_W-1:0]   prev_mem  [MEM_DEPTH];

   logic [GEN_BITS:0]   state_rd_ff;
   logic [LINK_W-1:0]   next_rd_ff, prev_rd_ff;

   logic [OP_W-1:0]     op_ff, op_in;
   logic [CMP_W-1:0]    hslot_ff, hslot_in;
   logic [GEN_BITS-1:0] hgen_ff, hgen_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [LINK_W-1:0]   free_head_ff, free_head_in;
   logic [LINK_W-1:0]   tail_ff, tail_in;
   logic [LINK_W-1:0]   used_ff, used_in;
   logic [LINK_W-1:0]   live_ff, live_in;
   logic [LINK_W-1:0]   released_ff, released_in;
   logic                disposed_ff, disposed_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [HSLOT_W-1:0]  res_slot_ff, res_slot_in;
   logic [HGEN_W-1:0]   res_gen_ff, res_gen_in;
   logic                res_alive_ff, res_alive_in;

   logic [STATUS_W-1:0] out_status_ff;
   logic [HSLOT_W-1:0]  out_slot_ff;
   logic [HGEN_W-1:0]   out_gen_ff;
   logic                out_alive_ff;
   logic [COUNT_W-1:0]  out_live_ff;
   logic [COUNT_W-1:0]  out_released_ff;

   logic                st_we, nx_we, pv_we;
   logic [SLOT_W-1:0]   st_waddr, nx_waddr, pv_waddr, rd_addr;
   logic [GEN_BITS:0]   st_wdata;
   logic [LINK_W-1:0]   nx_wdata, pv_wdata;

   logic                free_valid, tail_valid, used_room, in_range;
   logic                rd_live, rd_match, prev_valid, next_valid;
   logic [GEN_BITS-1:0] rd_gen, new_gen;
   logic [SLOT_W-1:0]   new_slot;
   logic [SLOT_W:0]     new_slot_link;
   logic [SLOT_W:0]     slot_link;
   logic [SLOT_W+HSLOT_W-1:0] new_slot_wide;
   logic [GEN_BITS+HGEN_W-1:0] new_gen_wide;
   logic [LINK_W+COUNT_W-1:0]  live_wide, released_wide;

   assign free_valid = free_head_ff < LINK_NONE;
   assign tail_valid = tail_ff < LINK_NONE;
   assign used_room  = used_ff < LINK_NONE;
   assign in_range   = hslot_ff < {{HSLOT_W{1'b0}}, used_ff};
   assign rd_live    = state_rd_ff[GEN_BITS];
   assign rd_gen     = state_rd_ff[GEN_BITS-1:0];
   assign rd_match   = rd_live && ((op_ff == OP_DISPOSE) || (rd_gen == hgen_ff));
   assign prev_valid = prev_rd_ff < LINK_NONE;
   assign next_valid = next_rd_ff < LINK_NONE;

   assign new_slot      = free_valid ? free_head_ff[SLOT_W-1:0] : used_ff[SLOT_W-1:0];
   assign new_gen       = free_valid ? rd_gen : '0;
   assign new_slot_link = {1'b0, new_slot};
   assign slot_link     = {1'b0, slot_ff};
   assign new_slot_wide = {{HSLOT_W{1'b0}}, new_slot};
   assign new_gen_wide  = {{HGEN_W{1'b0}}, new_gen};
   assign live_wide     = {{COUNT_W{1'b0}}, live_ff};
   assign released_wide = {{COUNT_W{1'b0}}, released_ff};

   always_comb begin
      case (op_ff)
         OP_CREATE: begin
            sts.lookup_final = disposed_ff || (!free_valid && !used_room);
            sts.update_final = !tail_valid;
         end
         OP_RELEASE: begin
            sts.lookup_final = !in_range;
            sts.update_final = !rd_match;
         end
         OP_QUERY: begin
            sts.lookup_final = !in_range;
            sts.update_final = 1'b1;
         end
         default: begin
            sts.lookup_final = disposed_ff || !tail_valid;
            sts.update_final = !rd_match;
         end
      endcase
      sts.walk_again = (op_ff == OP_DISPOSE) && tail_valid;
   end

   always_comb begin
      op_in         = op_ff;
      hslot_in      = hslot_ff;
      hgen_in       = hgen_ff;
      slot_in       = slot_ff;
      free_head_in  = free_head_ff;
      tail_in       = tail_ff;
      used_in       = used_ff;
      live_in       = live_ff;
      released_in   = released_ff;
      disposed_in   = disposed_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_gen_in    = res_gen_ff;
      res_alive_in  = res_alive_ff;
      st_we         = 1'b0;
      st_waddr      = slot_ff;
      st_wdata      = state_rd_ff;
      nx_we         = 1'b0;
      nx_waddr      = slot_ff;
      nx_wdata      = LINK_NONE;
      pv_we         = 1'b0;
      pv_waddr      = slot_ff;
      pv_wdata      = LINK_NONE;

      case (op_ff)
         OP_CREATE: rd_addr = free_head_ff[SLOT_W-1:0];
         OP_RELEASE, OP_QUERY: rd_addr = hslot_ff[SLOT_W-1:0];
         default: rd_addr = tail_ff[SLOT_W-1:0];
      endcase

      if (cmd.load) begin
         op_in         = req_operation;
         hslot_in      = {{LINK_W{1'b0}}, req_handle_slot};
         hgen_in       = req_handle_generation[GEN_BITS-1:0];
         released_in   = '0;
         res_status_in = ST_OK;
         res_slot_in   = '0;
         res_gen_in    = '0;
         res_alive_in  = 1'b0;
      end

      if (cmd.lookup) begin
         slot_in = rd_addr;
         case (op_ff)
            OP_CREATE: begin
               if (disposed_ff) begin
                  res_status_in = ST_DISPOSED;
               end else if (!free_valid && !used_room) begin
                  res_status_in = ST_FULL;
               end
            end
            OP_RELEASE: begin
               if (!in_range) begin
                  res_status_in = ST_STALE;
               end
            end
            OP_QUERY: begin
               res_status_in = ST_OK;
            end
            default: begin
               if (disposed_ff) begin
                  res_status_in = ST_AGAIN;
               end else if (!tail_valid) begin
                  disposed_in = 1'b1;
               end
            end
         endcase
      end

      if (cmd.update) begin
         case (op_ff)
            OP_CREATE: begin
               if (free_valid) begin
                  free_head_in = next_rd_ff;
               end else begin
                  used_in = used_ff + LINK_W'(1);
               end
               st_we       = 1'b1;
               st_waddr    = new_slot;
               st_wdata    = {1'b1, new_gen};
               pv_we       = 1'b1;
               pv_waddr    = new_slot;
               pv_wdata    = tail_ff;
               nx_we       = 1'b1;
               nx_waddr    = new_slot;
               nx_wdata    = LINK_NONE;
               slot_in     = new_slot;
               res_slot_in = new_slot_wide[HSLOT_W-1:0];
               res_gen_in  = new_gen_wide[HGEN_W-1:0];
               live_in     = live_ff + LINK_W'(1);
               if (!tail_valid) begin
                  tail_in = LINK_W'(new_slot_link);
               end
            end
            OP_QUERY: begin
               res_alive_in = rd_match;
            end
            default: begin
               if (!rd_match) begin
                  res_status_in = ST_STALE;
               end else begin
                  st_we    = 1'b1;
                  st_wdata = {1'b0, rd_gen + GEN_BITS'(1)};
                  if (prev_valid) begin
                     nx_we    = 1'b1;
                     nx_waddr = prev_rd_ff[SLOT_W-1:0];
                     nx_wdata = next_rd_ff;
                  end
                  if (next_valid) begin
                     pv_we    = 1'b1;
                     pv_waddr = next_rd_ff[SLOT_W-1:0];
                     pv_wdata = prev_rd_ff;
                  end else begin
                     tail_in = prev_rd_ff;
                  end
                  live_in = live_ff - LINK_W'(1);
               end
            end
         endcase
      end

      if (cmd.link) begin
         if (op_ff == OP_CREATE) begin
            nx_we    = 1'b1;
            nx_waddr = tail_ff[SLOT_W-1:0];
            nx_wdata = LINK_W'(slot_link);
            tail_in  = LINK_W'(slot_link);
         end else begin
            nx_we        = 1'b1;
            nx_waddr     = slot_ff;
            nx_wdata     = free_head_ff;
            free_head_in = LINK_W'(slot_link);
            if (op_ff == OP_DISPOSE) begin
               released_in = released_ff + LINK_W'(1);
               if (!tail_valid) begin
                  disposed_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         state_mem[st_waddr] <= st_wdata;
      end
      if (nx_we) begin
         next_mem[nx_waddr] <= nx_wdata;
      end
      if (pv_we) begin
         prev_mem[pv_waddr] <= pv_wdata;
      end
      if (cmd.lookup) begin
         state_rd_ff <= state_mem[rd_addr];
         next_rd_ff  <= next_mem[rd_addr];
         prev_rd_ff  <= prev_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff <= LINK_NONE;
         tail_ff      <= LINK_NONE;
         used_ff      <= '0;
         live_ff      <= '0;
         disposed_ff  <= 1'b0;
         op_ff        <= OP_CREATE;
      end else begin
         free_head_ff <= free_head_in;
         tail_ff      <= tail_in;
         used_ff      <= used_in;
         live_ff      <= live_in;
         disposed_ff  <= disposed_in;
         op_ff        <= op_in;
      end
   end

   always_ff @(posedge clock) begin
      hslot_ff      <= hslot_in;
      hgen_ff       <= hgen_in;
      slot_ff       <= slot_in;
      released_ff   <= released_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_gen_ff    <= res_gen_in;
      res_alive_ff  <= res_alive_in;
      if (cmd.emit) begin
         out_status_ff   <= res_status_ff;
         out_slot_ff     <= res_slot_ff;
         out_gen_ff      <= res_gen_ff;
         out_alive_ff    <= res_alive_ff;
         out_live_ff     <= live_wide[COUNT_W-1:0];
         out_released_ff <= released_wide[COUNT_W-1:0];
      end
   end

   assign rsp_status            = out_status_ff;
   assign rsp_result_slot       = out_slot_ff;
   assign rsp_result_generation = out_gen_ff;
   assign rsp_handle_alive      = out_alive_ff;
   assign rsp_live_count        = out_live_ff;
   assign rsp_released_count    = out_released_ff;

endmodule
`default_nettype wire

[rtl/core/ght_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Generational handle table sequencer
// Steps each request through lookup, update and link phases and owns the
// request and response handshakes.
// ============================================================================
module ght_ctrl import ght_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire ght_sts_type sts,
   output      ght_cmd_type cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_LOOKUP = 3'd1;
   localparam logic [2:0] S_UPDATE = 3'd2;
   localparam logic [2:0] S_LINK   = 3'd3;
   localparam logic [2:0] S_DONE   = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd.load   = (state_ff == S_IDLE) && req_valid;
      cmd.lookup = state_ff == S_LOOKUP;
      cmd.update = state_ff == S_UPDATE;
      cmd.link   = state_ff == S_LINK;
      cmd.emit   = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            state_in = sts.lookup_final ? S_DONE : S_UPDATE;
         end
         S_UPDATE: begin
            state_in = sts.update_final ? S_DONE : S_LINK;
         end
         S_LINK: begin
            state_in = sts.walk_again ? S_LOOKUP : S_DONE;
         end
         S_DONE: begin
            if (cmd.emit) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

[rtl/core/generational_handle_table.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Generational handle table
// Hands out slot and generation pairs, validates and retires them, and can
// release every live slot newest first in one dispose request.
// ============================================================================
// Each request is taken one at a time. A create runs a lookup read, an update
// write and a link write, and ends after the update on an empty registration
// list. A release runs the same three steps and a query the first two. A
// release or query of a slot that was never handed out ends after the lookup,
// a release of a stale handle after the update, and a create refused as full
// or disposed after the lookup. A dispose repeats the three steps once per live
// slot, or ends after the lookup when nothing is live or the table is already
// disposed. The steps follow from the single read and write port of each slot
// table. The next request can be accepted at the edge after the response turns
// valid, while that response still waits in the output register; a response
// that is still waiting holds the next one in its last step.
module generational_handle_table import ght_pkg::*; #(
   parameter int NUM_SLOTS = NUM_SLOTS_DEFAULT,
   parameter int GEN_BITS  = GEN_BITS_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   ght_req_if.sink  req_ch,
   ght_rsp_if.source rsp_ch
);

   ght_cmd_type cmd;
   ght_sts_type sts;

   ght_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ght_datapath #(
      .NUM_SLOTS (NUM_SLOTS),
      .GEN_BITS  (GEN_BITS)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .sts                   (sts),
      .req_operation         (req_ch.operation),
      .req_handle_slot       (req_ch.handle_slot),
      .req_handle_generation (req_ch.handle_generation),
      .rsp_status            (rsp_ch.status),
      .rsp_result_slot       (rsp_ch.result_slot),
      .rsp_result_generation (rsp_ch.result_generation),
      .rsp_handle_alive      (rsp_ch.handle_alive),
      .rsp_live_count        (rsp_ch.live_count),
      .rsp_released_count    (rsp_ch.released_count)
   );

endmodule
`default_nettype wire
